// ===== sv/cscd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscd_pkg: shared definitions for the series color derivation block
// Widths, fixed-point constants, register indexes and small helper
// functions used by the channel interfaces and the datapath.
// ----------------------------------------------------------------------------
package cscd_pkg;

	localparam int SERIES_INDEX_BITS = 8;
	// Hue offsets are 8 or 12 degrees per tier, with tier at most 2**(bits-1).
	localparam int OFF_W = SERIES_INDEX_BITS + 3;

	localparam int ONE_Q = 65536;
	localparam int CFG_AW = 3;

	typedef enum logic [0:0] {
		REG_FALLBACK = 1'b0
	} reg_idx_t;

	// Saturation clamp bounds, already divided by 100.
	localparam logic [15:0] SI_MIN = 16'(55 * ONE_Q / 100);
	localparam logic [15:0] SI_MAX = 16'(85 * ONE_Q / 100);

	// Lightness in Q16 fractions of one for each lightness the tiers produce.
	localparam int LI_25 = 25 * ONE_Q / 100;
	localparam int LI_35 = 35 * ONE_Q / 100;
	localparam int LI_66 = 66 * ONE_Q / 100;
	localparam int LI_77 = 77 * ONE_Q / 100;
	localparam int LI_78 = 78 * ONE_Q / 100;

	// Chroma factor 1 - |2L - 1| for those lightness values.
	localparam int CF_25 = (2 * LI_25 > ONE_Q) ? 2 * ONE_Q - 2 * LI_25 : 2 * LI_25;
	localparam int CF_35 = (2 * LI_35 > ONE_Q) ? 2 * ONE_Q - 2 * LI_35 : 2 * LI_35;
	localparam int CF_66 = (2 * LI_66 > ONE_Q) ? 2 * ONE_Q - 2 * LI_66 : 2 * LI_66;
	localparam int CF_77 = (2 * LI_77 > ONE_Q) ? 2 * ONE_Q - 2 * LI_77 : 2 * LI_77;
	localparam int CF_78 = (2 * LI_78 > ONE_Q) ? 2 * ONE_Q - 2 * LI_78 : 2 * LI_78;

	// Reciprocal of 60 scaled by 2**28, rounded up; exact for values below 2**22.
	localparam int RECIP60 = (2 ** 28 + 59) / 60;

	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] q;
	} div8_t;

	// Eight restoring division steps on an 8-bit divisor.
	function automatic div8_t div8(input logic [7:0] rem_in, input logic [7:0] bits,
			input logic [7:0] den);
		logic [8:0] r;
		div8_t res;
		r = {1'b0, rem_in};
		res.q = '0;
		for (int i = 7; i >= 0; i--) begin
			r = {r[7:0], bits[i]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				res.q[i] = 1'b1;
			end
		end
		res.rem = r[7:0];
		return res;
	endfunction

	// Reduction modulo 360 by conditional subtraction of shifted multiples.
	function automatic logic [8:0] mod360(input logic [OFF_W-1:0] v);
		logic [OFF_W+8:0] r;
		r = (OFF_W + 9)'(v);
		for (int k = OFF_W - 9; k >= 0; k--) begin
			if (r >= (OFF_W + 9)'(360 << k)) begin
				r = r - (OFF_W + 9)'(360 << k);
			end
		end
		return r[8:0];
	endfunction

	// Scale a Q16 channel value to 0..255 with rounding half up.
	function automatic logic [7:0] chan_out(input logic [16:0] v);
		logic [25:0] t;
		t = {v, 8'b0} - 26'(v) + 26'(32768);
		return (t[25:16] > 10'd255) ? 8'd255 : t[23:16];
	endfunction

endpackage

// ===== sv/cscd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscd_req_if / cscd_rsp_if: request and response channels
// Valid/ready channels carrying one color request word and one derived
// color word.
// ----------------------------------------------------------------------------
interface cscd_req_if;
	import cscd_pkg::*;
	logic valid;
	logic ready;
	logic [SERIES_INDEX_BITS-1:0] series_index;
	logic accent_valid;
	logic [7:0] accent_red;
	logic [7:0] accent_green;
	logic [7:0] accent_blue;
	logic bg_present;
	logic [7:0] bg_red;
	logic [7:0] bg_green;
	logic [7:0] bg_blue;

	modport source (output valid, series_index, accent_valid, accent_red, accent_green,
		accent_blue, bg_present, bg_red, bg_green, bg_blue, input ready);
	modport sink (input valid, series_index, accent_valid, accent_red, accent_green,
		accent_blue, bg_present, bg_red, bg_green, bg_blue, output ready);
endinterface

interface cscd_rsp_if;
	logic valid;
	logic ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== sv/chart_series_color_derive_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chart_series_color_derive_unit: per-series chart color derivation
// Converts an accent color to HSL, adapts lightness and hue to the series
// tier and the background, and converts back to RGB in a nine-stage pipeline.
// ----------------------------------------------------------------------------
// Each accepted request word is registered in stages 1 to 9 in turn before its response word leaves.
// Throughput: one word per cycle; every stage has its own valid bit and a
// stage only holds when the one after it is full and stalled.
// The two divisions run as 24 restoring steps spread eight to a stage.
// Reset clears all valid bits and the fallback color register to zero.
module chart_series_color_derive_unit (
	input  logic clk,
	input  logic arst_n,
	cscd_req_if.sink color_req,
	cscd_rsp_if.source color_rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [cscd_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import cscd_pkg::*;

	localparam int NST = 9;
	localparam int B = SERIES_INDEX_BITS;

	// One record travels the whole pipeline; each stage fills in its fields.
	typedef struct packed {
		logic pass;            // series zero: color passes through
		logic [23:0] rgb;      // pass-through color, final color at the last stage
		logic dark;
		logic dz;              // gray accent
		logic neg;             // hue numerator negative
		logic [1:0] base;      // hue base: 0, 120 or 240 degrees
		logic [15:0] li;
		logic [15:0] cf;
		logic [8:0] off;
		logic [7:0] d;
		logic [7:0] sden;
		logic [7:0] hrem;
		logic [23:0] hbits;
		logic [23:0] hq;
		logic [7:0] srem;
		logic [23:0] sq;
		logic [15:0] c;
		logic [24:0] hue;
		logic [2:0] sec;
		logic [21:0] y;
		logic [15:0] t;
		logic [15:0] x;
		logic [15:0] m;
	} pipe_t;

	pipe_t pipe_s [1:NST];
	pipe_t nxt [1:NST];
	logic [NST:1] vld_s;
	logic [NST+1:1] rdy;
	logic [23:0] fallback_q;

	// ---------------- configuration port ----------------
	// Only one register exists; bit 2 of the address selects it or nothing.
	assign pready = 1'b1;
	always_comb begin
		if (paddr[2] == REG_FALLBACK) begin
			prdata = {8'b0, fallback_q};
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FALLBACK) begin
			fallback_q <= pwdata[23:0];
		end
	end

	// ---------------- handshake ----------------
	// A stage can take a word when it is empty or its word moves on.
	always_comb begin
		rdy[NST+1] = color_rsp.ready;
		for (int k = NST; k >= 1; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end
	assign color_req.ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= color_req.valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1] && color_req.valid) begin
			pipe_s[1] <= nxt[1];
		end
		for (int k = 2; k <= NST; k++) begin
			if (rdy[k] && vld_s[k-1]) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	// ---------------- stage 1: color selection, min/max, tier ----------------
	logic [7:0] r0, g0, b0, hi0, lo0, d0, an0;
	logic [8:0] sum0;
	logic [8:0] bsum0;
	logic [7:0] bhi0, blo0;
	logic signed [8:0] n0;
	logic [13:0] n60;
	logic [B:0] ip1;
	logic [B-1:0] tier;
	logic dark_bg, dark0;
	logic [OFF_W-1:0] prod_off;

	always_comb begin
		if (color_req.accent_valid) begin
			r0 = color_req.accent_red;
			g0 = color_req.accent_green;
			b0 = color_req.accent_blue;
		end else begin
			r0 = fallback_q[23:16];
			g0 = fallback_q[15:8];
			b0 = fallback_q[7:0];
		end
		hi0 = (r0 > g0) ? r0 : g0;
		hi0 = (hi0 > b0) ? hi0 : b0;
		lo0 = (r0 < g0) ? r0 : g0;
		lo0 = (lo0 < b0) ? lo0 : b0;
		sum0 = {1'b0, hi0} + {1'b0, lo0};
		d0 = hi0 - lo0;

		// Background is dark when its lightness is under one half.
		bhi0 = (color_req.bg_red > color_req.bg_green) ? color_req.bg_red : color_req.bg_green;
		bhi0 = (bhi0 > color_req.bg_blue) ? bhi0 : color_req.bg_blue;
		blo0 = (color_req.bg_red < color_req.bg_green) ? color_req.bg_red : color_req.bg_green;
		blo0 = (blo0 < color_req.bg_blue) ? blo0 : color_req.bg_blue;
		bsum0 = {1'b0, bhi0} + {1'b0, blo0};
		dark_bg = color_req.bg_present && (bsum0 < 9'd255);
		dark0 = dark_bg ^ color_req.series_index[0];

		ip1 = {1'b0, color_req.series_index} + (B + 1)'(1);
		tier = ip1[B:1];

		nxt[1] = '0;
		nxt[1].pass = (color_req.series_index == '0);
		nxt[1].rgb = {r0, g0, b0};
		nxt[1].dark = dark0;
		nxt[1].dz = (d0 == 8'd0);
		nxt[1].d = d0;
		nxt[1].sden = (sum0 > 9'd255) ? 8'(9'd510 - sum0) : sum0[7:0];

		// Red is tested first, then green.
		if (hi0 == r0) begin
			n0 = $signed({1'b0, g0}) - $signed({1'b0, b0});
			nxt[1].base = 2'd0;
		end else if (hi0 == g0) begin
			n0 = $signed({1'b0, b0}) - $signed({1'b0, r0});
			nxt[1].base = 2'd1;
		end else begin
			n0 = $signed({1'b0, r0}) - $signed({1'b0, g0});
			nxt[1].base = 2'd2;
		end
		nxt[1].neg = n0[8];
		an0 = n0[8] ? 8'(-n0) : n0[7:0];
		n60 = {an0, 6'b0} - {4'b0, an0, 2'b0};
		// Dividend is n*60*2**16; its top six bits seed the remainder.
		nxt[1].hrem = {2'b0, n60[13:8]};
		nxt[1].hbits = {n60[7:0], 16'b0};
		nxt[1].srem = 8'd0;

		// Lightness per tier and side, and the hue offset modulo 360.
		if (dark0) begin
			prod_off = {tier, 3'b0};
			if (tier == B'(1)) begin
				nxt[1].li = 16'(LI_35);
				nxt[1].cf = 16'(CF_35);
			end else begin
				nxt[1].li = 16'(LI_25);
				nxt[1].cf = 16'(CF_25);
			end
		end else begin
			prod_off = {tier, 3'b0} + {1'b0, tier, 2'b0};
			if (tier == B'(1)) begin
				nxt[1].li = 16'(LI_66);
				nxt[1].cf = 16'(CF_66);
			end else if (tier == B'(2)) begin
				nxt[1].li = 16'(LI_77);
				nxt[1].cf = 16'(CF_77);
			end else begin
				nxt[1].li = 16'(LI_78);
				nxt[1].cf = 16'(CF_78);
			end
		end
		nxt[1].off = mod360(prod_off);
	end

	// ---------------- stages 2..4: hue and saturation dividers ----------------
	// Hue quotient is n*60*2**16/d, saturation quotient is d*2**16/denominator,
	// eight quotient bits per stage for both.
	for (genvar k = 2; k <= 4; k++) begin : g_div
		localparam int J = k - 2;
		div8_t dh, ds;
		logic [7:0] sbits;
		always_comb begin
			sbits = (J == 0) ? pipe_s[k-1].d : 8'd0;
			dh = div8(pipe_s[k-1].hrem, pipe_s[k-1].hbits[23-8*J -: 8], pipe_s[k-1].d);
			ds = div8(pipe_s[k-1].srem, sbits, pipe_s[k-1].sden);
			nxt[k] = pipe_s[k-1];
			nxt[k].hrem = dh.rem;
			nxt[k].hq[23-8*J -: 8] = dh.q;
			nxt[k].srem = ds.rem;
			nxt[k].sq[23-8*J -: 8] = ds.q;
		end
	end

	// ---------------- stage 5: hue assembly, saturation clamp, chroma ----------------
	logic signed [26:0] hs5;
	logic [24:0] base5;
	logic [15:0] si5;
	logic [31:0] cprod5;

	always_comb begin
		case (pipe_s[4].base)
			2'd1: base5 = 25'(120 * ONE_Q);
			2'd2: base5 = 25'(240 * ONE_Q);
			default: base5 = '0;
		endcase
		if (pipe_s[4].neg) begin
			hs5 = $signed({2'b0, base5}) - $signed({3'b0, pipe_s[4].hq});
		end else begin
			hs5 = $signed({2'b0, base5}) + $signed({3'b0, pipe_s[4].hq});
		end
		if (hs5 < 0) begin
			hs5 = hs5 + 27'(360 * ONE_Q);
		end
		if (pipe_s[4].dz) begin
			hs5 = '0;
		end

		// A gray accent has zero saturation, which clamps up to the minimum.
		if (pipe_s[4].dz || pipe_s[4].sq < 24'(SI_MIN)) begin
			si5 = SI_MIN;
		end else if (pipe_s[4].sq > 24'(SI_MAX)) begin
			si5 = SI_MAX;
		end else begin
			si5 = pipe_s[4].sq[15:0];
		end
		cprod5 = pipe_s[4].cf * si5;

		nxt[5] = pipe_s[4];
		nxt[5].hue = hs5[24:0];
		nxt[5].c = cprod5[31:16];
	end

	// ---------------- stage 6: hue shift and sector ----------------
	logic signed [10:0] deg6;
	logic [8:0] dg6;
	logic [5:0] rm6;

	always_comb begin
		if (pipe_s[5].dark) begin
			deg6 = $signed({2'b0, pipe_s[5].hue[24:16]}) - $signed({2'b0, pipe_s[5].off});
			if (deg6 < 0) begin
				deg6 = deg6 + 11'sd360;
			end
		end else begin
			deg6 = $signed({2'b0, pipe_s[5].hue[24:16]}) + $signed({2'b0, pipe_s[5].off});
			if (deg6 >= 11'sd360) begin
				deg6 = deg6 - 11'sd360;
			end
		end
		dg6 = deg6[8:0];

		nxt[6] = pipe_s[5];
		if (dg6 < 9'd60) begin
			nxt[6].sec = 3'd0;
			rm6 = 6'(dg6);
		end else if (dg6 < 9'd120) begin
			nxt[6].sec = 3'd1;
			rm6 = 6'(dg6 - 9'd60);
		end else if (dg6 < 9'd180) begin
			nxt[6].sec = 3'd2;
			rm6 = 6'(dg6 - 9'd120);
		end else if (dg6 < 9'd240) begin
			nxt[6].sec = 3'd3;
			rm6 = 6'(dg6 - 9'd180);
		end else if (dg6 < 9'd300) begin
			nxt[6].sec = 3'd4;
			rm6 = 6'(dg6 - 9'd240);
		end else begin
			nxt[6].sec = 3'd5;
			rm6 = 6'(dg6 - 9'd300);
		end
		nxt[6].y = {rm6, pipe_s[5].hue[15:0]};
	end

	// ---------------- stage 7: position within the sector ----------------
	logic [44:0] tprod7;

	always_comb begin
		tprod7 = pipe_s[6].y * 23'(RECIP60);
		nxt[7] = pipe_s[6];
		nxt[7].t = tprod7[43:28];
	end

	// ---------------- stage 8: second component and offset ----------------
	logic [16:0] g8;
	logic [32:0] xprod8;

	always_comb begin
		g8 = pipe_s[7].sec[0] ? 17'(ONE_Q) - {1'b0, pipe_s[7].t} : {1'b0, pipe_s[7].t};
		xprod8 = pipe_s[7].c * g8;
		nxt[8] = pipe_s[7];
		nxt[8].x = xprod8[31:16];
		nxt[8].m = pipe_s[7].li - {1'b0, pipe_s[7].c[15:1]};
	end

	// ---------------- stage 9: channel assignment and scaling ----------------
	logic [15:0] vr9, vg9, vb9;

	always_comb begin
		case (pipe_s[8].sec)
			3'd0: begin vr9 = pipe_s[8].c; vg9 = pipe_s[8].x; vb9 = '0; end
			3'd1: begin vr9 = pipe_s[8].x; vg9 = pipe_s[8].c; vb9 = '0; end
			3'd2: begin vr9 = '0; vg9 = pipe_s[8].c; vb9 = pipe_s[8].x; end
			3'd3: begin vr9 = '0; vg9 = pipe_s[8].x; vb9 = pipe_s[8].c; end
			3'd4: begin vr9 = pipe_s[8].x; vg9 = '0; vb9 = pipe_s[8].c; end
			default: begin vr9 = pipe_s[8].c; vg9 = '0; vb9 = pipe_s[8].x; end
		endcase
		nxt[9] = pipe_s[8];
		if (!pipe_s[8].pass) begin
			nxt[9].rgb = {chan_out({1'b0, vr9} + {1'b0, pipe_s[8].m}),
				chan_out({1'b0, vg9} + {1'b0, pipe_s[8].m}),
				chan_out({1'b0, vb9} + {1'b0, pipe_s[8].m})};
		end
	end

	assign color_rsp.valid = vld_s[NST];
	assign color_rsp.out_red = pipe_s[NST].rgb[23:16];
	assign color_rsp.out_green = pipe_s[NST].rgb[15:8];
	assign color_rsp.out_blue = pipe_s[NST].rgb[7:0];

	// ---------------- assertions ----------------
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		color_req.valid && color_req.ready |=> vld_s[1])
		else $error("accepted word did not enter the first stage");

	a_hue_quot: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[4] && !pipe_s[4].dz |-> pipe_s[4].hq <= 24'(60 * ONE_Q))
		else $error("hue quotient out of range");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5] |-> pipe_s[5].hue < 25'(360 * ONE_Q))
		else $error("hue outside one turn");

	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[6] |-> pipe_s[6].sec <= 3'd5 && pipe_s[6].y < 22'(60 * ONE_Q))
		else $error("sector decode out of range");

endmodule
